>>> design/brp_pkg.sv
package brp_pkg;

    // field widths
    localparam int AMT_W      = 64;
    localparam int SIZE_W     = 32;
    localparam int HALF_W     = 32;
    localparam int PROD_W     = 128;
    localparam int DIV_STAGES = 64;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    // status codes
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_OVERSIZE = 1'b1;

    // input request
    typedef struct packed {
        logic [AMT_W-1:0]  amount;
        logic [SIZE_W-1:0] median_size;
        logic [SIZE_W-1:0] block_size;
    } req_t;

    // output response
    typedef struct packed {
        logic [AMT_W-1:0] penalized_amount;
        logic             status;
    } rsp_t;

    // request class decided by the front
    typedef enum logic [1:0] {
        CLS_OVERSIZE,
        CLS_ZERO,
        CLS_PASS,
        CLS_SCALE
    } cls_t;

    // classified work item held in the queue
    typedef struct packed {
        cls_t             cls;
        logic [AMT_W-1:0] amount;
        logic [AMT_W-1:0] mult;
        logic [AMT_W-1:0] divisor;
    } item_t;

endpackage

>>> design/brp_front.sv
module brp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  brp_pkg::req_t req,
    output logic          item_valid,
    output brp_pkg::item_t item,
    input  logic          q_full
);
    import brp_pkg::*;

    logic             f_valid_reg, f_valid_next;
    item_t            f_item_reg, f_item_next;
    logic [SIZE_W:0]  twice;
    logic [SIZE_W:0]  diff;
    logic [SIZE_W:0]  size_ext;
    logic             load;
    logic             push;

    // handshake
    assign push      = f_valid_reg && !q_full;
    assign req_stall = f_valid_reg && q_full;
    assign load      = req_valid && !req_stall;

    // classify and form the scale factors
    assign twice    = {req.median_size, 1'b0};
    assign size_ext = {1'b0, req.block_size};
    assign diff     = twice - size_ext;

    always_comb
    begin
        f_item_next.amount  = req.amount;
        f_item_next.mult    = AMT_W'(diff[SIZE_W-1:0]) * AMT_W'(req.block_size);
        f_item_next.divisor = AMT_W'(req.median_size) * AMT_W'(req.median_size);
        if (size_ext > twice)
        begin
            f_item_next.cls = CLS_OVERSIZE;
        end
        else if (req.amount == '0)
        begin
            f_item_next.cls = CLS_ZERO;
        end
        else if (req.block_size <= req.median_size)
        begin
            f_item_next.cls = CLS_PASS;
        end
        else
        begin
            f_item_next.cls = CLS_SCALE;
        end
    end

    // stage valid
    always_comb
    begin
        f_valid_next = f_valid_reg;
        if (load)
        begin
            f_valid_next = 1'b1;
        end
        else if (push)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            f_item_reg <= f_item_next;
        end
    end

    assign item_valid = f_valid_reg;
    assign item       = f_item_reg;

endmodule

>>> design/brp_queue.sv
module brp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  brp_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output brp_pkg::item_t head
);
    import brp_pkg::*;

    item_t           mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0] cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign full       = (cnt_reg == Q_CW'(Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    // pointers and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/brp_back.sv
module brp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  brp_pkg::item_t head,
    output logic           pop,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output brp_pkg::rsp_t  rsp
);
    import brp_pkg::*;

    logic en;

    // multiply stage 0: partial products
    logic                 m0_valid_reg;
    cls_t                 m0_cls_reg;
    logic [AMT_W-1:0]     m0_amount_reg, m0_divisor_reg;
    logic [AMT_W-1:0]     m0_p00_reg, m0_p01_reg, m0_p10_reg, m0_p11_reg;

    // multiply stage 1: middle sum
    logic                 m1_valid_reg;
    cls_t                 m1_cls_reg;
    logic [AMT_W-1:0]     m1_amount_reg, m1_divisor_reg;
    logic [AMT_W-1:0]     m1_p00_reg, m1_p11_reg;
    logic [AMT_W:0]       m1_mid_reg;

    // divider pipeline, index 0 holds the full product
    logic                 dv_valid_reg   [DIV_STAGES+1];
    cls_t                 dv_cls_reg     [DIV_STAGES+1];
    logic [AMT_W-1:0]     dv_amount_reg  [DIV_STAGES+1];
    logic [AMT_W-1:0]     dv_divisor_reg [DIV_STAGES+1];
    logic [AMT_W-1:0]     dv_rem_reg     [DIV_STAGES+1];
    logic [AMT_W-1:0]     dv_lq_reg      [DIV_STAGES+1];
    logic [PROD_W-1:0]    prod;

    // output register
    logic                 out_valid_reg;
    rsp_t                 out_rsp_reg, out_rsp_next;

    // whole pipeline moves together when the output can drain
    assign en  = !out_valid_reg || !rsp_stall;
    assign pop = en && head_valid;

    // full 128-bit product
    assign prod = {m1_p11_reg, m1_p00_reg}
                + {{(PROD_W-AMT_W-HALF_W-1){1'b0}}, m1_mid_reg, {HALF_W{1'b0}}};

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m0_valid_reg    <= 1'b0;
            m1_valid_reg    <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            m0_valid_reg    <= head_valid;
            m1_valid_reg    <= m0_valid_reg;
            dv_valid_reg[0] <= m1_valid_reg;
        end
    end

    // multiplier payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_cls_reg     <= head.cls;
            m0_amount_reg  <= head.amount;
            m0_divisor_reg <= head.divisor;
            m0_p00_reg     <= AMT_W'(head.amount[HALF_W-1:0])
                            * AMT_W'(head.mult[HALF_W-1:0]);
            m0_p01_reg     <= AMT_W'(head.amount[HALF_W-1:0])
                            * AMT_W'(head.mult[AMT_W-1:HALF_W]);
            m0_p10_reg     <= AMT_W'(head.amount[AMT_W-1:HALF_W])
                            * AMT_W'(head.mult[HALF_W-1:0]);
            m0_p11_reg     <= AMT_W'(head.amount[AMT_W-1:HALF_W])
                            * AMT_W'(head.mult[AMT_W-1:HALF_W]);

            m1_cls_reg     <= m0_cls_reg;
            m1_amount_reg  <= m0_amount_reg;
            m1_divisor_reg <= m0_divisor_reg;
            m1_p00_reg     <= m0_p00_reg;
            m1_p11_reg     <= m0_p11_reg;
            m1_mid_reg     <= {1'b0, m0_p01_reg} + {1'b0, m0_p10_reg};

            dv_cls_reg[0]     <= m1_cls_reg;
            dv_amount_reg[0]  <= m1_amount_reg;
            dv_divisor_reg[0] <= m1_divisor_reg;
            dv_rem_reg[0]     <= prod[PROD_W-1:AMT_W];
            dv_lq_reg[0]      <= prod[AMT_W-1:0];
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        logic [AMT_W:0] cur;
        logic [AMT_W:0] diff;
        logic           ge;

        assign cur  = {dv_rem_reg[k], dv_lq_reg[k][AMT_W-1]};
        assign diff = cur - {1'b0, dv_divisor_reg[k]};
        assign ge   = (cur >= {1'b0, dv_divisor_reg[k]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_cls_reg[k+1]     <= dv_cls_reg[k];
                dv_amount_reg[k+1]  <= dv_amount_reg[k];
                dv_divisor_reg[k+1] <= dv_divisor_reg[k];
                dv_rem_reg[k+1]     <= ge ? diff[AMT_W-1:0] : cur[AMT_W-1:0];
                dv_lq_reg[k+1]      <= {dv_lq_reg[k][AMT_W-2:0], ge};
            end
        end
    end

    // pick the response by class
    always_comb
    begin
        out_rsp_next.status           = STATUS_OK;
        out_rsp_next.penalized_amount = '0;
        case (dv_cls_reg[DIV_STAGES])
            CLS_OVERSIZE:
            begin
                out_rsp_next.status = STATUS_OVERSIZE;
            end
            CLS_ZERO:
            begin
                out_rsp_next.penalized_amount = '0;
            end
            CLS_PASS:
            begin
                out_rsp_next.penalized_amount = dv_amount_reg[DIV_STAGES];
            end
            CLS_SCALE:
            begin
                out_rsp_next.penalized_amount = dv_lq_reg[DIV_STAGES];
            end
            default:
            begin
                out_rsp_next.penalized_amount = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_rsp_reg <= out_rsp_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_rsp_reg;

endmodule

>>> design/block_reward_penalty_top.sv
// Block reward penalty: for each request (amount, median size M, block size S) returns
// floor(amount * (2M - S) * S / M^2) when M < S <= 2M, the amount itself when S <= M,
// zero when the amount is zero, and zero with status set when S > 2M. One request is
// taken per cycle when req_stall is low; one response comes out per request, in order.
// The path from request to response is a front register that classifies the request
// and forms (2M - S) * S and M^2, a four-entry queue, three stages for the 64 x 64
// product, a 64-stage restoring divider by M^2 with one quotient bit per stage, and the
// output register. Divider depth sets latency, not rate: one per cycle when no stall.
module block_reward_penalty_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  brp_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output brp_pkg::rsp_t rsp
);
    import brp_pkg::*;

    logic  item_valid;
    item_t item;
    logic  q_full;
    logic  pop;
    logic  head_valid;
    item_t head;

    // accept and classify
    brp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .item_valid (item_valid),
        .item       (item),
        .q_full     (q_full)
    );

    // decoupling queue
    brp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (item_valid),
        .push_item  (item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // multiply and divide
    brp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule
